// ----- rtl/pvsi_pkg.sv -----
// pvsi_pkg: types, codes and the saturation helper for the polynomial evaluator
// used by every module of the block; depends on nothing
`default_nettype none

package pvsi_pkg;

   // command codes
   localparam logic CMD_VALUE    = 1'b0;
   localparam logic CMD_INTEGRAL = 1'b1;

   // register indexes
   localparam int REG_START     = 0;
   localparam int REG_DEGREE    = 1;
   localparam int REG_COEF_BASE = 2;

   localparam int DEGREE_W = 3;

   typedef struct packed {
      logic               command;
      logic signed [31:0] point_or_lower;
      logic signed [31:0] upper_limit;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] slope;
      logic               overflow;
   } rsp_type;

   // one item on its way down the horner chain: two lanes a and b
   typedef struct packed {
      logic               valid;
      logic               command;
      logic signed [31:0] ta;
      logic signed [31:0] tb;
      logic signed [31:0] ra;
      logic signed [31:0] rb;
      logic               ovf;
   } lane_type;

   // terms added at one horner step
   typedef struct packed {
      logic signed [31:0] cval;
      logic signed [31:0] eval;
      logic signed [31:0] ival;
      logic               eflag;
   } term_type;

   typedef struct packed {
      logic               flag;
      logic signed [31:0] val;
   } sat_type;

   // clamp a wide signed value to 32 bits
   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      r.flag = 1'b0;
      r.val  = v[31:0];
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r.flag = 1'b1;
         r.val  = 32'sh7FFF_FFFF;
      end else if (v < 64'shFFFF_FFFF_8000_0000) begin
         r.flag = 1'b1;
         r.val  = 32'sh8000_0000;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pvsi_if.sv -----
// pvsi_if: valid/ready channel carrying one payload item
// payload type is set by the instantiating level
`default_nettype none

interface pvsi_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pvsi_coef.sv -----
// pvsi_coef: configuration registers and per-step horner terms
// depends on pvsi_pkg; integral terms use reciprocal multiply with one correction
`default_nettype none

module pvsi_coef import pvsi_pkg::*; #(
   parameter int MAX_DEGREE = 5,
   parameter int INDEX_W    = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [31:0]        csr_data,
   output logic signed [31:0] start,
   output term_type           terms [0:MAX_DEGREE+1]
);

   localparam int DW = $clog2(MAX_DEGREE + 1);

   logic signed [31:0]   start_ff;
   logic [DEGREE_W-1:0]  degree_ff;
   logic signed [31:0]   coef_ff [0:MAX_DEGREE];
   logic [DW-1:0]        deg_used;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         degree_ff <= '0;
         for (int k = 0; k <= MAX_DEGREE; k++) coef_ff[k] <= '0;
      end else if (csr_wr_en) begin
         if (int'(csr_index) == REG_START) start_ff <= csr_data;
         if (int'(csr_index) == REG_DEGREE) degree_ff <= csr_data[DEGREE_W-1:0];
         for (int k = 0; k <= MAX_DEGREE; k++) begin
            if (int'(csr_index) == REG_COEF_BASE + k) coef_ff[k] <= csr_data;
         end
      end
   end

   assign start = start_ff;

   // degrees above the supported maximum clamp to it
   always_comb begin
      if (int'(degree_ff) > MAX_DEGREE) deg_used = DW'(MAX_DEGREE);
      else deg_used = DW'(degree_ff);
   end

   for (genvar j = 0; j <= MAX_DEGREE + 1; j++) begin : g_term
      // value term: coefficient j
      if (j <= MAX_DEGREE) begin : g_cval
         assign terms[j].cval = (int'(deg_used) >= j) ? coef_ff[j] : 32'sd0;
      end else begin : g_cnone
         assign terms[j].cval = 32'sd0;
      end

      // slope term: (j+1) * coefficient j+1
      if (j < MAX_DEGREE) begin : g_eval
         logic signed [31:0] eval_ff;
         logic               eflag_ff;
         sat_type            es;
         assign es = sat32(64'(coef_ff[j+1]) * 64'(j + 1));
         always_ff @(posedge clock) begin
            if (int'(deg_used) >= j + 1) begin
               eval_ff  <= es.val;
               eflag_ff <= es.flag;
            end else begin
               eval_ff  <= 32'sd0;
               eflag_ff <= 1'b0;
            end
         end
         assign terms[j].eval  = eval_ff;
         assign terms[j].eflag = eflag_ff;
      end else begin : g_enone
         assign terms[j].eval  = 32'sd0;
         assign terms[j].eflag = 1'b0;
      end

      // integral term: coefficient j-1 / j, truncated toward zero
      if (j >= 1) begin : g_ival
         localparam logic [32:0] RECIP = 33'((64'd1 << 32) / j);
         logic [63:0]        prod_ff;
         logic [31:0]        mag_ff;
         logic               neg_ff;
         logic [31:0]        mag_in;
         logic [31:0]        q0;
         logic [37:0]        rem;
         logic [31:0]        quo;
         logic signed [31:0] ival_ff;

         assign mag_in = coef_ff[j-1][31] ? 32'(-64'(coef_ff[j-1])) : 32'(coef_ff[j-1]);

         always_ff @(posedge clock) begin
            prod_ff <= 64'(mag_in) * 64'(RECIP);
            mag_ff  <= mag_in;
            neg_ff  <= coef_ff[j-1][31];
         end

         // estimate is exact or one low
         assign q0  = prod_ff[63:32];
         assign rem = 38'(mag_ff) - 38'(q0) * 38'(j);
         assign quo = q0 + 32'(rem >= 38'(j));

         always_ff @(posedge clock) begin
            if (int'(deg_used) >= j - 1) ival_ff <= neg_ff ? -$signed(quo) : $signed(quo);
            else ival_ff <= 32'sd0;
         end
         assign terms[j].ival = ival_ff;
      end else begin : g_inone
         assign terms[j].ival = 32'sd0;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pvsi_step.sv -----
// pvsi_step: one horner step for two lanes, multiply stage then add/saturate stage
// depends on pvsi_pkg
`default_nettype none

module pvsi_step import pvsi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  lane_type lane_in,
   input  term_type term,
   output lane_type lane_out
);

   lane_type           mul_ff;
   logic signed [63:0] pa_ff, pb_ff;
   logic signed [63:0] pa_in, pb_in;
   logic signed [31:0] ka, kb;
   sat_type            sa, sb;
   lane_type           out_ff, out_in;

   // exact products
   assign pa_in = lane_in.ra * lane_in.ta;
   assign pb_in = lane_in.rb * lane_in.tb;

   // term selection by command
   always_comb begin
      if (mul_ff.command == CMD_VALUE) begin
         ka = term.cval;
         kb = term.eval;
      end else begin
         ka = term.ival;
         kb = term.ival;
      end
   end

   // floor shift, add term, clamp
   assign sa = sat32((pa_ff >>> FRAC_BITS) + 64'(ka));
   assign sb = sat32((pb_ff >>> FRAC_BITS) + 64'(kb));

   always_comb begin
      out_in     = mul_ff;
      out_in.ra  = sa.val;
      out_in.rb  = sb.val;
      out_in.ovf = mul_ff.ovf | sa.flag | sb.flag |
                   ((mul_ff.command == CMD_VALUE) & term.eflag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         mul_ff <= lane_in;
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         out_ff <= out_in;
      end
   end

   assign lane_out = out_ff;

endmodule

`default_nettype wire

// ----- rtl/polynomial_value_slope_integral.sv -----
// polynomial_value_slope_integral: pipelined horner evaluation of value, slope, integral
// depends on pvsi_pkg, pvsi_if, pvsi_coef, pvsi_step
//
//   channel   dir   transfer when       carries
//   req_ch    in    valid & ready       command, point_or_lower, upper_limit
//   rsp_ch    out   valid & ready       value, slope, overflow
//   csr_*     in    csr_wr_en high      register index and data
//
// one item per cycle while rsp_ch does not stall; the pipe is the
// chain of MAX_DEGREE+2 two-stage multiply/add steps plus input, origin and output stages
// reset is synchronous; it clears all valid bits and the configuration registers
// a stall at rsp_ch holds every stage; req_ch.ready falls only then
`default_nettype none

module polynomial_value_slope_integral import pvsi_pkg::*; #(
   parameter int MAX_DEGREE = 5,
   parameter int FRAC_BITS  = 16,
   localparam int CSR_INDEX_W = $clog2(MAX_DEGREE + 3)
) (
   input  logic                   clock,
   input  logic                   reset,
   pvsi_if.sink                   req_ch,
   pvsi_if.source                 rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   localparam int NSTEP = MAX_DEGREE + 2;

   logic               advance;
   logic signed [31:0] start;
   term_type           terms [0:MAX_DEGREE+1];

   logic               in_valid_ff;
   req_type            in_ff;
   lane_type           t_ff, t_in;
   lane_type           lanes [0:NSTEP];

   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff;
   logic               rsp_cmd_ff;

   sat_type            sat_a, sat_b, sat_d;
   logic signed [31:0] lo, hi;

   // whole pipe moves unless a result waits
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   pvsi_coef #(
      .MAX_DEGREE (MAX_DEGREE),
      .INDEX_W    (CSR_INDEX_W)
   ) u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .start     (start),
      .terms     (terms)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_ch.valid;
         in_ff       <= req_ch.data;
      end
   end

   // local positions, limits ordered for the integral
   always_comb begin
      if (in_ff.command == CMD_INTEGRAL && in_ff.point_or_lower > in_ff.upper_limit) begin
         lo = in_ff.upper_limit;
         hi = in_ff.point_or_lower;
      end else begin
         lo = in_ff.point_or_lower;
         hi = in_ff.upper_limit;
      end
      sat_a = sat32(64'(lo) - 64'(start));
      sat_b = sat32(64'(hi) - 64'(start));
      t_in.valid   = in_valid_ff;
      t_in.command = in_ff.command;
      t_in.ta      = sat_a.val;
      t_in.ra      = 32'sd0;
      t_in.rb      = 32'sd0;
      if (in_ff.command == CMD_VALUE) begin
         t_in.tb  = sat_a.val;
         t_in.ovf = sat_a.flag;
      end else begin
         t_in.tb  = sat_b.val;
         t_in.ovf = sat_a.flag | sat_b.flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff.valid <= 1'b0;
      end else if (advance) begin
         t_ff <= t_in;
      end
   end

   assign lanes[0] = t_ff;

   // horner chain, highest term first
   for (genvar s = 0; s < NSTEP; s++) begin : g_step
      pvsi_step #(
         .FRAC_BITS (FRAC_BITS)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .lane_in  (lanes[s]),
         .term     (terms[MAX_DEGREE + 1 - s]),
         .lane_out (lanes[s+1])
      );
   end

   // result assembly
   always_comb begin
      sat_d = sat32(64'(lanes[NSTEP].rb) - 64'(lanes[NSTEP].ra));
      if (lanes[NSTEP].command == CMD_VALUE) begin
         rsp_in.value    = lanes[NSTEP].ra;
         rsp_in.slope    = lanes[NSTEP].rb;
         rsp_in.overflow = lanes[NSTEP].ovf;
      end else begin
         rsp_in.value    = sat_d.val;
         rsp_in.slope    = 32'sd0;
         rsp_in.overflow = lanes[NSTEP].ovf | sat_d.flag;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= lanes[NSTEP].valid;
         rsp_ff       <= rsp_in;
         rsp_cmd_ff   <= lanes[NSTEP].command;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

   // checks
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input taken while a result is stalled");

   a_integral_no_slope: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_cmd_ff == CMD_INTEGRAL |-> rsp_ch.data.slope == 32'sd0)
      else $error("integral result carries a slope");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
